>>> rtl/core/tutc_pkg.sv
// ----------------------------------------------------------------------------
// Time unit tick converter package
// Shared status codes, configuration summary, datapath commands and the
// power-of-ten scale table.
// ----------------------------------------------------------------------------
package tutc_pkg;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned ExpWidth  = 5;
  localparam int unsigned StatWidth = 3;
  localparam int unsigned AddrWidth = 2;

  localparam logic [StatWidth-1:0] ST_OK   = 3'd0;
  localparam logic [StatWidth-1:0] ST_UNIT = 3'd1;
  localparam logic [StatWidth-1:0] ST_PREC = 3'd2;
  localparam logic [StatWidth-1:0] ST_MULT = 3'd3;
  localparam logic [StatWidth-1:0] ST_OVF  = 3'd4;

  localparam logic [AddrWidth-1:0] REG_UNIT = 2'd0;
  localparam logic [AddrWidth-1:0] REG_PREC = 2'd1;
  localparam logic [AddrWidth-1:0] REG_MULT = 2'd2;

  typedef struct packed {
    logic [StatWidth-1:0] status;
    logic [DataWidth-1:0] mult;
    logic [DataWidth-1:0] scale;
  } cfg_info_t;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
    logic round_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  function automatic logic [DataWidth-1:0] pow10(input logic [3:0] e);
    logic [DataWidth-1:0] r;
    unique case (e)
      4'd0:  r = 64'd1;
      4'd1:  r = 64'd10;
      4'd2:  r = 64'd100;
      4'd3:  r = 64'd1000;
      4'd4:  r = 64'd10000;
      4'd5:  r = 64'd100000;
      4'd6:  r = 64'd1000000;
      4'd7:  r = 64'd10000000;
      4'd8:  r = 64'd100000000;
      4'd9:  r = 64'd1000000000;
      4'd10: r = 64'd10000000000;
      4'd11: r = 64'd100000000000;
      4'd12: r = 64'd1000000000000;
      4'd13: r = 64'd10000000000000;
      4'd14: r = 64'd100000000000000;
      4'd15: r = 64'd1000000000000000;
      default: r = 64'd1;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/tutc_cfg.sv
// ----------------------------------------------------------------------------
// Time unit tick converter configuration registers
// Holds the exponents and multiplier, checks them and looks up the scale.
// ----------------------------------------------------------------------------
module tutc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tutc_pkg::AddrWidth-1:0]      cfg_addr,
  input  logic [tutc_pkg::DataWidth-1:0]      cfg_wdata,
  output tutc_pkg::cfg_info_t                 info
);

  logic signed [tutc_pkg::ExpWidth-1:0] unit_exp;
  logic signed [tutc_pkg::ExpWidth-1:0] prec_exp;
  logic [tutc_pkg::DataWidth-1:0]       tick_mult;
  logic signed [tutc_pkg::ExpWidth-1:0] exp_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_exp  <= '0;
      prec_exp  <= '0;
      tick_mult <= 64'd1;
    end else if (cfg_we) begin
      if (cfg_addr == tutc_pkg::REG_UNIT) begin
        unit_exp <= cfg_wdata[tutc_pkg::ExpWidth-1:0];
      end else if (cfg_addr == tutc_pkg::REG_PREC) begin
        prec_exp <= cfg_wdata[tutc_pkg::ExpWidth-1:0];
      end else if (cfg_addr == tutc_pkg::REG_MULT) begin
        tick_mult <= cfg_wdata;
      end
    end
  end

  assign exp_diff = unit_exp - prec_exp;

  always_comb begin
    info.mult  = tick_mult;
    info.scale = tutc_pkg::pow10(exp_diff[3:0]);
    if (unit_exp > 5'sd0 || unit_exp < -5'sd15) begin
      info.status = tutc_pkg::ST_UNIT;
    end else if (prec_exp > unit_exp || prec_exp < -5'sd15) begin
      info.status = tutc_pkg::ST_PREC;
    end else if (tick_mult == '0) begin
      info.status = tutc_pkg::ST_MULT;
    end else begin
      info.status = tutc_pkg::ST_OK;
    end
  end

endmodule

>>> rtl/core/tutc_datapath.sv
// ----------------------------------------------------------------------------
// Time unit tick converter datapath
// Shift-add multiplier and restoring divider sharing one work register,
// followed by half-up rounding and the output register.
// ----------------------------------------------------------------------------
module tutc_datapath #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tutc_pkg::dp_cmd_t                   cmd,
  output tutc_pkg::dp_stat_t                  stat,
  input  tutc_pkg::cfg_info_t                 info,
  input  logic                                op,
  input  logic [tutc_pkg::DataWidth-1:0]      value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tutc_pkg::DataWidth-1:0]      out_data,
  output logic [tutc_pkg::StatWidth-1:0]      out_status
);

  localparam int unsigned NW = VALUE_WIDTH + tutc_pkg::DataWidth;

  logic [NW-1:0]                    work;
  logic [tutc_pkg::DataWidth-1:0]   mcand;
  logic [tutc_pkg::DataWidth-1:0]   divisor;
  logic [tutc_pkg::DataWidth-1:0]   rem;
  logic                             rnd;
  logic [tutc_pkg::StatWidth-1:0]   cfg_status;

  logic [tutc_pkg::DataWidth:0]     sum;
  logic [tutc_pkg::DataWidth:0]     trial;
  logic [tutc_pkg::DataWidth:0]     diff;
  logic                             ge;
  logic [NW:0]                      rounded;
  logic                             ovf;

  always_comb begin
    sum = {1'b0, work[NW-1:VALUE_WIDTH]} + (work[0] ? {1'b0, mcand} : '0);
    trial = {rem, work[NW-1]};
    ge = trial >= {1'b0, divisor};
    diff = trial - {1'b0, divisor};
    rounded = {1'b0, work} + {{NW{1'b0}}, rnd};
    ovf = rounded[NW:VALUE_WIDTH] != '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work       <= {{tutc_pkg::DataWidth{1'b0}}, value[VALUE_WIDTH-1:0]};
      mcand      <= op ? info.scale : info.mult;
      divisor    <= op ? info.mult : info.scale;
      rem        <= '0;
      cfg_status <= info.status;
    end else if (cmd.mul_step) begin
      work <= {sum, work[VALUE_WIDTH-1:1]};
    end else if (cmd.div_step) begin
      work <= {work[NW-2:0], ge};
      rem  <= ge ? diff[tutc_pkg::DataWidth-1:0] : trial[tutc_pkg::DataWidth-1:0];
    end
    if (cmd.round_step) begin
      rnd <= rem >= (divisor - rem);
    end
    if (cmd.load) begin
      rnd <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (cfg_status != tutc_pkg::ST_OK) begin
        out_data   <= '0;
        out_status <= cfg_status;
      end else if (ovf) begin
        out_data   <= '0;
        out_status <= tutc_pkg::ST_OVF;
      end else begin
        out_data   <= tutc_pkg::DataWidth'(rounded[VALUE_WIDTH-1:0]);
        out_status <= tutc_pkg::ST_OK;
      end
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

endmodule

>>> rtl/core/tutc_ctrl.sv
// ----------------------------------------------------------------------------
// Time unit tick converter controller
// Sequences load, multiply, divide, rounding and result hand-off.
// ----------------------------------------------------------------------------
module tutc_ctrl #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cfg_error,
  input  tutc_pkg::dp_stat_t    stat,
  output tutc_pkg::dp_cmd_t     cmd
);

  localparam int unsigned NW = VALUE_WIDTH + tutc_pkg::DataWidth;
  localparam int unsigned CW = $clog2(NW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_ROUND,
    S_FINISH
  } state_t;

  state_t        state;
  logic [CW-1:0] count;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd            = '0;
    cmd.load       = in_ready && in_valid;
    cmd.mul_step   = state == S_MUL;
    cmd.div_step   = state == S_DIV;
    cmd.round_step = state == S_ROUND;
    cmd.finish     = state == S_FINISH && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          count <= '0;
          if (in_valid) begin
            state <= cfg_error ? S_FINISH : S_MUL;
          end
        end
        S_MUL: begin
          if (count == CW'(VALUE_WIDTH - 1)) begin
            count <= '0;
            state <= S_DIV;
          end else begin
            count <= count + CW'(1);
          end
        end
        S_DIV: begin
          if (count == CW'(NW - 1)) begin
            count <= '0;
            state <= S_ROUND;
          end else begin
            count <= count + CW'(1);
          end
        end
        S_ROUND: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!stat.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/time_unit_tick_converter_core.sv
// ----------------------------------------------------------------------------
// Time unit tick converter core
// Rounded multiply-divide between scheduler ticks and local time units.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A request with a valid configuration
// passes from acceptance through the one-bit-per-cycle shift-add multiplier,
// the one-bit-per-cycle restoring divider over the full product and the
// rounding step to the result register; the next request is accepted only
// after that result is written. A request with a bad configuration goes from
// acceptance straight to the finish step. A finished result waits in the
// output register while the next request is accepted, and the core holds its
// own finished result until that register is free. Configuration is to be
// written only while the core is idle; the core itself does not enforce it.
module time_unit_tick_converter_core #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tutc_pkg::DataWidth-1:0]      s_tdata,   // value
  input  logic [0:0]                          s_tuser,   // op
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tutc_pkg::DataWidth-1:0]      m_tdata,   // converted
  output logic [tutc_pkg::StatWidth-1:0]      m_tuser,   // status
  input  logic                                cfg_we,
  input  logic [tutc_pkg::AddrWidth-1:0]      cfg_addr,
  input  logic [tutc_pkg::DataWidth-1:0]      cfg_wdata
);

  tutc_pkg::cfg_info_t  info;
  tutc_pkg::dp_cmd_t    cmd;
  tutc_pkg::dp_stat_t   stat;

  tutc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .info      (info)
  );

  tutc_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cfg_error (info.status != tutc_pkg::ST_OK),
    .stat      (stat),
    .cmd       (cmd)
  );

  tutc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .info       (info),
    .op         (s_tuser[0]),
    .value      (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_status (m_tuser)
  );

endmodule

>>> sim/tb_time_unit_tick_converter_core.sv
// ----------------------------------------------------------------------------
// Testbench for the time unit tick converter core
// Streams conversion requests through the core under changing configurations
// and random handshake idling, predicts each rounded multiply-divide result
// with an exact 128-bit calculation, and compares every returned result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_time_unit_tick_converter_core;

  localparam logic OP_TO_LOCAL = 1'b0;
  localparam logic OP_TO_TICKS = 1'b1;
  localparam logic [tutc_pkg::AddrWidth-1:0] REG_SPARE = 2'd3;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic                           op;
    logic [tutc_pkg::DataWidth-1:0] value;
  } conv_req_t;

  typedef struct packed {
    logic [tutc_pkg::DataWidth-1:0] converted;
    logic [tutc_pkg::StatWidth-1:0] status;
  } conv_res_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [tutc_pkg::DataWidth-1:0] s_tdata = '0;
  logic [0:0]                     s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [tutc_pkg::DataWidth-1:0] m_tdata;
  logic [tutc_pkg::StatWidth-1:0] m_tuser;
  logic                           cfg_we = 1'b0;
  logic [tutc_pkg::AddrWidth-1:0] cfg_addr = '0;
  logic [tutc_pkg::DataWidth-1:0] cfg_wdata = '0;

  logic signed [tutc_pkg::ExpWidth-1:0] unit_exp = '0;
  logic signed [tutc_pkg::ExpWidth-1:0] prec_exp = '0;
  logic [tutc_pkg::DataWidth-1:0]       tick_mult = 64'd1;

  conv_req_t   req_queue[$];
  conv_res_t   awaited_results[$];
  bit          req_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holdoff_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count = 0;

  time_unit_tick_converter_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [tutc_pkg::DataWidth-1:0] scale_of();
    logic [tutc_pkg::DataWidth-1:0] s;
    int e;
    s = 64'd1;
    for (e = int'(prec_exp); e < int'(unit_exp); e++) s = s * 64'd10;
    return s;
  endfunction

  function automatic conv_res_t convert_time(conv_req_t r);
    conv_res_t                      res;
    logic [tutc_pkg::DataWidth-1:0] mul;
    logic [tutc_pkg::DataWidth-1:0] div;
    logic [tutc_pkg::DataWidth-1:0] rem;
    logic [127:0]                   prod;
    logic [127:0]                   quo;
    res.converted = '0;
    res.status = tutc_pkg::ST_OK;
    if (int'(unit_exp) > 0 || int'(unit_exp) < -15) begin
      res.status = tutc_pkg::ST_UNIT;
    end else if (int'(prec_exp) > int'(unit_exp) || int'(prec_exp) < -15) begin
      res.status = tutc_pkg::ST_PREC;
    end else if (tick_mult == '0) begin
      res.status = tutc_pkg::ST_MULT;
    end else begin
      if (r.op == OP_TO_LOCAL) begin
        mul = tick_mult;
        div = scale_of();
      end else begin
        mul = scale_of();
        div = tick_mult;
      end
      prod = {64'd0, r.value} * {64'd0, mul};
      quo = prod / {64'd0, div};
      rem = 64'(prod % {64'd0, div});
      // Half up: the quotient is raised when twice the remainder reaches the divisor.
      if (rem >= div - rem) quo = quo + 128'd1;
      if (quo[127:64] != '0) res.status = tutc_pkg::ST_OVF;
      else res.converted = quo[63:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [tutc_pkg::DataWidth-1:0] got,
                                 logic [tutc_pkg::DataWidth-1:0] want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    fail_count++;
  endtask

  // Request driver.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !req_taken) begin
      s_tvalid <= 1'b1;
    end else if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      s_tvalid <= 1'b1;
      s_tdata <= req_queue[0].value;
      s_tuser <= req_queue[0].op;
    end else begin
      s_tvalid <= 1'b0;
      s_tdata <= {$urandom, $urandom};
      s_tuser <= 1'($urandom);
    end
    req_taken = 1'b0;
  end

  // Result receiver.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holdoff_left != 0) begin
      m_tready <= 1'b0;
      holdoff_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor, prediction and watchdog.
  always @(posedge clk) begin : monitor
    conv_res_t want;
    conv_req_t req;
    bit        s_fire;
    bit        m_fire;
    if (!rst) begin
      s_fire = s_tvalid && s_tready;
      m_fire = m_tvalid && m_tready;
      if (m_fire) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no request outstanding", m_tdata, '0);
        end else begin
          want = awaited_results.pop_front();
          if (m_tdata !== want.converted)
            report_mismatch("converted", m_tdata, want.converted);
          if (m_tuser !== want.status)
            report_mismatch("status", 64'(m_tuser), 64'(want.status));
        end
      end
      if (s_fire) begin
        req = req_queue.pop_front();
        awaited_results.push_back(convert_time(req));
        req_taken = 1'b1;
      end
      if (s_fire || m_fire || (req_queue.size() == 0 && awaited_results.size() == 0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  task automatic drain();
    while (req_queue.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [tutc_pkg::AddrWidth-1:0] addr,
                           logic [tutc_pkg::DataWidth-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      tutc_pkg::REG_UNIT: unit_exp = data[tutc_pkg::ExpWidth-1:0];
      tutc_pkg::REG_PREC: prec_exp = data[tutc_pkg::ExpWidth-1:0];
      tutc_pkg::REG_MULT: tick_mult = data;
      default: ;
    endcase
  endtask

  task automatic set_cfg(logic signed [tutc_pkg::ExpWidth-1:0] u,
                         logic signed [tutc_pkg::ExpWidth-1:0] p,
                         logic [tutc_pkg::DataWidth-1:0] m);
    logic [tutc_pkg::DataWidth-1:0] raw;
    drain();
    raw = {$urandom, $urandom};
    cfg_write(tutc_pkg::REG_UNIT, {raw[tutc_pkg::DataWidth-1:tutc_pkg::ExpWidth], u});
    raw = {$urandom, $urandom};
    cfg_write(tutc_pkg::REG_PREC, {raw[tutc_pkg::DataWidth-1:tutc_pkg::ExpWidth], p});
    cfg_write(tutc_pkg::REG_MULT, m);
    if ($urandom_range(3) == 0) cfg_write(REG_SPARE, {$urandom, $urandom});
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_req(logic op, logic [tutc_pkg::DataWidth-1:0] value);
    conv_req_t r;
    r.op = op;
    r.value = value;
    req_queue.push_back(r);
  endtask

  task automatic pick_config();
    logic signed [tutc_pkg::ExpWidth-1:0] u;
    logic signed [tutc_pkg::ExpWidth-1:0] p;
    logic [tutc_pkg::DataWidth-1:0]       m;
    int unsigned                          kind;
    kind = $urandom_range(9);
    u = 5'(0 - int'($urandom_range(15)));
    p = 5'(int'(u) - int'($urandom_range(15 + int'(u))));
    case ($urandom_range(5))
      0: m = 64'd1;
      1: m = 64'($urandom_range(1, 1000));
      2: m = 64'd10 ** $urandom_range(15);
      3: m = {$urandom, $urandom};
      4: m = '1;
      default: m = {$urandom, $urandom} >> $urandom_range(63);
    endcase
    if (m == '0) m = 64'd1;
    if (kind == 0) begin
      u = 5'($urandom_range(1, 16));
    end else if (kind == 1) begin
      if ($urandom_range(1) == 0) p = -5'sd16;
      else p = 5'(int'(u) + int'($urandom_range(1, 1 - int'(u))));
    end else if (kind == 2) begin
      m = '0;
    end
    set_cfg(u, p, m);
  endtask

  function automatic logic [tutc_pkg::DataWidth-1:0] random_value();
    logic [tutc_pkg::DataWidth-1:0] s;
    logic [tutc_pkg::DataWidth-1:0] v;
    s = scale_of();
    case ($urandom_range(5))
      0: v = 64'($urandom_range(1000));
      1: v = {$urandom, $urandom};
      2: v = {$urandom, $urandom} >> $urandom_range(63);
      3: v = 64'($urandom_range(1000)) * s + (s >> 1) + 64'($urandom_range(2)) - 64'd1;
      4: v = ($urandom_range(1) != 0) ? '1 : 64'($urandom_range(3));
      default: v = ~({$urandom, $urandom} >> $urandom_range(63));
    endcase
    return v;
  endfunction

  initial begin
    int ph;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Values straight out of reset.
    send_req(OP_TO_LOCAL, '0);
    send_req(OP_TO_LOCAL, '1);
    send_req(OP_TO_TICKS, '1);
    send_req(OP_TO_TICKS, 64'd1);

    // Rounding at and around one half.
    set_cfg(-5'sd8, -5'sd9, 64'd1);
    send_req(OP_TO_LOCAL, 64'd5);
    send_req(OP_TO_LOCAL, 64'd4);
    send_req(OP_TO_LOCAL, 64'd15);
    send_req(OP_TO_LOCAL, 64'd14);

    // Largest scale, including overflow.
    set_cfg(5'sd0, -5'sd15, 64'd1);
    send_req(OP_TO_LOCAL, '1);
    send_req(OP_TO_TICKS, '1);
    send_req(OP_TO_TICKS, 64'd1);

    set_cfg(5'sd0, 5'sd0, 64'd2);
    send_req(OP_TO_TICKS, 64'd1);
    send_req(OP_TO_TICKS, 64'd3);
    send_req(OP_TO_LOCAL, '1);

    set_cfg(-5'sd15, -5'sd15, '1);
    send_req(OP_TO_TICKS, '1);
    send_req(OP_TO_LOCAL, '1);
    send_req(OP_TO_LOCAL, '0);

    // Bad configurations of every kind, with each exponent out of range at either end.
    set_cfg(5'sd1, 5'sd0, 64'd1);
    send_req(OP_TO_LOCAL, 64'd5);
    set_cfg(-5'sd16, -5'sd16, 64'd1);
    send_req(OP_TO_TICKS, 64'd5);
    set_cfg(-5'sd3, -5'sd2, 64'd1);
    send_req(OP_TO_LOCAL, 64'd5);
    set_cfg(-5'sd3, -5'sd16, 64'd1);
    send_req(OP_TO_LOCAL, 64'd5);
    set_cfg(-5'sd3, -5'sd6, '0);
    send_req(OP_TO_LOCAL, 64'd5);
    send_req(OP_TO_TICKS, 64'd5);

    // A write to the unused register index must change nothing.
    set_cfg(-5'sd2, -5'sd5, 64'd7);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_SPARE;
    cfg_wdata <= {$urandom, $urandom};
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_req(OP_TO_LOCAL, 64'd12345);
    send_req(OP_TO_TICKS, 64'd12345);

    // The receiver holds off long enough for the core to back up its input.
    set_cfg(-5'sd6, -5'sd9, 64'd3);
    set_idle(0, 0);
    @(posedge clk);
    holdoff_left = 1000;
    repeat (8) send_req(1'($urandom), random_value());

    for (ph = 0; ph < 22; ph++) begin
      pick_config();
      case (ph % 4)
        0: set_idle(0, 0);
        1: set_idle(85, 0);
        2: set_idle(0, 85);
        default: set_idle(7, 7);
      endcase
      repeat (25) send_req(1'($urandom), random_value());
    end

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
